>>> sv/lsq_pkg.sv
// Shared constants, types and helpers for the largest ones square unit.
`timescale 1ns / 1ps
package lsq_pkg;

  // Largest matrix side that the line buffer can hold.
  localparam int MAX_DIM = 128;
  // Bits needed to address one column or one row.
  localparam int IDX_W = $clog2(MAX_DIM);
  // Bits needed for a square side, which can reach MAX_DIM itself.
  localparam int SIZE_W = $clog2(MAX_DIM + 1);
  // Width of a configuration register and of the result field.
  localparam int CFG_W = 8;
  localparam int SIDE_W = 8;
  // Configuration bus widths.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map, as word indexes.
  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_e;

  // Control handed to the line buffer for each accepted cell.
  typedef struct packed {
    logic             shift;
    logic [IDX_W-1:0] tail;
  } lsq_line_ctl_t;

  // Index of the last row or column in use for a register value.
  // Zero is taken as one, and anything above MAX_DIM as MAX_DIM.
  function automatic logic [IDX_W-1:0] last_index(logic [CFG_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (int'(v) == 0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(int'(v) - 1);
    end
    return r;
  endfunction

endpackage

>>> sv/lsq_cell.sv
// One stage of the line buffer: holds a square side and passes it along.
`timescale 1ns / 1ps
module lsq_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic                       ins_sel_i,
  input  logic [lsq_pkg::SIZE_W-1:0] ins_data_i,
  input  logic [lsq_pkg::SIZE_W-1:0] nbr_data_i,
  output logic [lsq_pkg::SIZE_W-1:0] data_o
);
  import lsq_pkg::*;

  logic [SIZE_W-1:0] data_q;
  logic [SIZE_W-1:0] data_d;

  // The tail cell takes the new side; every other cell takes its neighbour's.
  assign data_d = ins_sel_i ? ins_data_i : nbr_data_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

>>> sv/lsq_line_buf.sv
// Variable-length line buffer built as a chain of shifting cells.
`timescale 1ns / 1ps
module lsq_line_buf (
  input  logic                       clk_i,
  input  lsq_pkg::lsq_line_ctl_t     ctl_i,
  input  logic [lsq_pkg::SIZE_W-1:0] ins_data_i,
  output logic [lsq_pkg::SIZE_W-1:0] head_o
);
  import lsq_pkg::*;

  logic [SIZE_W-1:0] cell_q [MAX_DIM];
  logic [SIZE_W-1:0] nbr    [MAX_DIM];
  logic [MAX_DIM-1:0] ins_sel;

  // A side enters at the tail, cell (columns - 1), and reaches the head
  // after exactly one row of transactions, just as the cell below needs it.
  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    assign ins_sel[i] = (ctl_i.tail == IDX_W'(i));
    if (i == MAX_DIM - 1) begin : g_end
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = cell_q[i+1];
    end
    lsq_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctl_i.shift),
      .ins_sel_i  (ins_sel[i]),
      .ins_data_i (ins_data_i),
      .nbr_data_i (nbr[i]),
      .data_o     (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

>>> sv/largest_ones_square_unit.sv
// Top level of the largest ones square unit: scan control, recurrence and ports.
//
// Usage: the cells of a binary matrix arrive one bit per transaction on the
// cell channel (cell_valid_i, cell_ready_o, cell_bit_i) in row-major order.
// The matrix size comes from two registers on the APB-style port: row_count
// at byte address 0 and col_count at byte address 4, both reset to 128.
// After the last cell of each matrix one transaction on the result channel
// (best_valid_o, best_ready_i, best_side_o) carries the side of the largest
// square made only of ones, or 0 when the matrix has none.
// Throughput is one cell per clock cycle; each cell's side is worked out in
// the cycle it is taken, from the left, upper-left and upper neighbours, the
// upper one coming from a chain of MAX_DIM shift cells that acts as a line
// buffer. The result is loaded into the output register as the
// final cell is taken. While the receiver stalls, cells are still taken
// until a second result would be due; the input then waits for the output
// register to empty. Reset puts the scan at the first row and column with an
// empty result register. A register write restarts the scan of the matrix.
`timescale 1ns / 1ps
module largest_ones_square_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Cell input channel
  input  logic                         cell_valid_i,
  output logic                         cell_ready_o,
  input  logic                         cell_bit_i,
  // Result output channel
  output logic                         best_valid_o,
  input  logic                         best_ready_i,
  output logic [lsq_pkg::SIDE_W-1:0]   best_side_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsq_pkg::PADDR_W-1:0]  paddr,
  input  logic [lsq_pkg::PDATA_W-1:0]  pwdata,
  output logic [lsq_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import lsq_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] row_count_q, col_count_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  // Scan state
  logic [IDX_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  col_q, col_d;
  logic [SIZE_W-1:0] left_q, left_d;
  logic [SIZE_W-1:0] diag_q, diag_d;
  logic [SIZE_W-1:0] best_q, best_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [SIZE_W-1:0] out_side_q;

  // Per-cell datapath
  logic              in_acc;
  logic [IDX_W-1:0]  row_last, col_last;
  logic              col_end, row_end, last_cell;
  logic [SIZE_W-1:0] head, up, lf, dg, min_ul, min3, size;
  lsq_line_ctl_t     line_ctl;

  // Register port: writes land on the access phase, reads are combinational.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count_q);
      REG_COL_COUNT: prdata = PDATA_W'(col_count_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CFG_W'(MAX_DIM);
      col_count_q <= CFG_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROW_COUNT: row_count_q <= pwdata[CFG_W-1:0];
        REG_COL_COUNT: col_count_q <= pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  // Handshakes: only the final cell of a matrix waits for the result register
  // to be free or to be emptied in this cycle; every other cell is taken.
  assign cell_ready_o = !out_valid_q || best_ready_i || !last_cell;
  assign in_acc       = cell_valid_i && cell_ready_o;

  assign row_last  = last_index(row_count_q);
  assign col_last  = last_index(col_count_q);
  assign col_end   = (col_q >= col_last);
  assign row_end   = (row_q >= row_last);
  assign last_cell = col_end && row_end;

  // Neighbour sides; outside the matrix they count as zero.
  assign up = (row_q != '0) ? head : '0;
  assign lf = (col_q != '0) ? left_q : '0;
  assign dg = ((row_q != '0) && (col_q != '0)) ? diag_q : '0;

  // Side of the square ending at this cell.
  assign min_ul = (up < lf) ? up : lf;
  assign min3   = (dg < min_ul) ? dg : min_ul;
  assign size   = cell_bit_i ? (min3 + SIZE_W'(1)) : '0;

  // Line buffer control: shift once per accepted cell, insert at the last column.
  assign line_ctl.shift = in_acc;
  assign line_ctl.tail  = col_last;

  lsq_line_buf u_line_buf (
    .clk_i      (clk_i),
    .ctl_i      (line_ctl),
    .ins_data_i (size),
    .head_o     (head)
  );

  // Next scan state.
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    left_d = left_q;
    diag_d = diag_q;
    best_d = best_q;
    if (cfg_we) begin
      row_d  = '0;
      col_d  = '0;
      left_d = '0;
      diag_d = '0;
      best_d = '0;
    end else if (in_acc) begin
      left_d = size;
      diag_d = up;
      best_d = (size > best_q) ? size : best_q;
      col_d  = col_q + IDX_W'(1);
      if (col_end) begin
        left_d = '0;
        diag_d = '0;
        col_d  = '0;
        row_d  = row_q + IDX_W'(1);
        if (row_end) begin
          row_d  = '0;
          best_d = '0;
        end
      end
    end
  end

  // Result register: loaded on the final cell, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (best_valid_o && best_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && last_cell && !cfg_we) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      left_q      <= '0;
      diag_q      <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      left_q      <= left_d;
      diag_q      <= diag_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_cell && !cfg_we) begin
      out_side_q <= (size > best_q) ? size : best_q;
    end
  end

  assign best_valid_o = out_valid_q;
  assign best_side_o  = SIDE_W'(out_side_q);

  // The scan position never runs past the matrix in use.
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= col_last)
    else $error("column index beyond last column");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= row_last)
    else $error("row index beyond last row");

  // A cell that is not the last of its matrix never raises a result.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !last_cell && !out_valid_q) |=> !best_valid_o)
    else $error("result raised before the final cell");

  // A filled cell that does not end the matrix leaves a non-zero best side.
  a_best_tracks_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cell_bit_i && !last_cell && !cfg_we) |=> (best_q != '0))
    else $error("best side lost a filled cell");

endmodule

>>> sim/tb_largest_ones_square_unit.sv
// Self-checking testbench for the largest ones square unit, with a scan predictor.
`timescale 1ns / 1ps
module tb_largest_ones_square_unit;
  import lsq_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 3;
  // Extra idle cycles that wait_idle adds once every owed side has arrived.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_CELLS = 700;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam longint TIMEOUT_NS = 64'd4_000_000;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cell_valid_i = 1'b0;
  logic                cell_ready_o;
  logic                cell_bit_i = 1'b0;
  logic                best_valid_o;
  logic                best_ready_i = 1'b0;
  logic [SIDE_W-1:0]   best_side_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  largest_ones_square_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_valid_i(cell_valid_i),
    .cell_ready_o(cell_ready_o),
    .cell_bit_i  (cell_bit_i),
    .best_valid_o(best_valid_o),
    .best_ready_i(best_ready_i),
    .best_side_o (best_side_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor state: register copies, scan position and the previous row's sides.
  logic [CFG_W-1:0]  row_cfg = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0]  col_cfg = CFG_W'(MAX_DIM);
  logic [SIDE_W-1:0] line_sides [MAX_DIM];
  logic [SIDE_W-1:0] left_side = '0;
  logic [SIDE_W-1:0] diag_side = '0;
  logic [SIDE_W-1:0] best_in_matrix = '0;
  int unsigned       scan_row = 0;
  int unsigned       scan_col = 0;

  // Sides still owed by the block, oldest first.
  logic [SIDE_W-1:0] best_due [$];

  // Idling controls shared by the sender, the receiver and the tests.
  int unsigned send_gap_pct = 0;
  int unsigned sink_gap_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned hold_offs_done = 0;

  int unsigned error_count = 0;
  int unsigned cells_sent = 0;
  int unsigned results_checked = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // A register value of zero counts as one, and anything above MAX_DIM as MAX_DIM.
  function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v);
    int unsigned d;
    d = v;
    if (d == 0) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  // Gap length: mostly none, otherwise mostly short with the odd long one.
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void restart_scan();
    left_side = '0;
    diag_side = '0;
    scan_row = 0;
    scan_col = 0;
    best_in_matrix = '0;
  endfunction

  // Advances the predicted scan by one cell and queues the side owed at the end of a matrix.
  function automatic void predict_cell(input logic filled);
    int unsigned rows, cols, r, c;
    logic [SIDE_W-1:0] up, lf, dg, least, side;
    rows = dim_in_use(row_cfg);
    cols = dim_in_use(col_cfg);
    r = scan_row;
    c = scan_col;
    if (r >= rows) r = rows - 1;
    if (c >= cols) c = 0;
    // Neighbours outside the matrix count as side zero.
    up = (r > 0) ? line_sides[c] : '0;
    lf = (c > 0) ? left_side : '0;
    dg = (r > 0 && c > 0) ? diag_side : '0;
    least = up;
    if (lf < least) least = lf;
    if (dg < least) least = dg;
    side = filled ? least + 1'b1 : '0;
    diag_side = up;
    line_sides[c] = side;
    left_side = side;
    if (side > best_in_matrix) best_in_matrix = side;
    if (c + 1 >= cols) begin
      left_side = '0;
      diag_side = '0;
      scan_col = 0;
      if (r + 1 >= rows) begin
        best_due.push_back(best_in_matrix);
        restart_scan();
      end else begin
        scan_row = r + 1;
      end
    end else begin
      scan_col = c + 1;
      scan_row = r;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offers one cell and waits for its transaction, after a random gap.
  task automatic send_cell(input logic filled);
    int unsigned gap;
    gap = pick_gap(send_gap_pct);
    if (gap != 0) begin
      cell_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_valid_i <= 1'b1;
    cell_bit_i <= filled;
    do @(posedge clk_i); while (!cell_ready_o);
    predict_cell(filled);
    cells_sent++;
  endtask

  // Stops offering cells and waits until every owed side has arrived.
  task automatic wait_idle();
    cell_valid_i <= 1'b0;
    while (best_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write with setup and access cycles; the upper data bits carry noise.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= PDATA_W'({$urandom(), value});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ROW_COUNT) begin
      row_cfg = value;
    end else begin
      col_cfg = value;
    end
    restart_scan();
  endtask

  // Register read with setup and access cycles, compared on the access edge.
  task automatic check_reg(input reg_idx_e idx, input logic [CFG_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(want)) report_mismatch("register read", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  initial begin : result_sink
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        gap_left = hold_off_cycles;
        hold_off_cycles = 0;
        hold_offs_done++;
      end else if (gap_left == 0) begin
        gap_left = pick_gap(sink_gap_pct);
      end
      if (gap_left != 0) begin
        best_ready_i <= 1'b0;
        gap_left--;
      end else begin
        best_ready_i <= 1'b1;
      end
    end
  end

  // Compares each result transaction with the oldest owed side.
  always @(posedge clk_i) begin : result_check
    logic [SIDE_W-1:0] want;
    if (rst_ni && best_valid_o && best_ready_i) begin
      if (best_due.size() == 0) begin
        report_mismatch("result with nothing owed", best_side_o, 0);
      end else begin
        want = best_due.pop_front();
        results_checked++;
        if (best_side_o !== want) report_mismatch("best_side", best_side_o, want);
      end
    end
  end

  // Both registers read 128 after reset; with only the row count changed, a
  // two-row matrix runs at the reset width of 128 columns.
  task automatic test_reset_size();
    send_gap_pct = 2;
    sink_gap_pct = 10;
    check_reg(REG_ROW_COUNT, CFG_W'(MAX_DIM));
    check_reg(REG_COL_COUNT, CFG_W'(MAX_DIM));
    write_reg(REG_ROW_COUNT, 8'd2);
    for (int i = 0; i < 2 * MAX_DIM; i++) send_cell($urandom_range(9) != 0);
    wait_idle();
  endtask

  // One-cell matrices, including a register value of zero taken as one.
  task automatic test_tiny_sizes();
    send_gap_pct = 20;
    sink_gap_pct = 20;
    set_size(8'd1, 8'd1);
    send_cell(1'b0);
    send_cell(1'b1);
    wait_idle();
    set_size(8'd0, 8'd0);
    send_cell(1'b1);
    send_cell(1'b0);
    wait_idle();
  endtask

  // A full 3 by 3 square, then a ring of ones with a hole in the middle.
  task automatic test_square_patterns();
    logic [8:0] ring;
    ring = 9'b111_101_111;
    set_size(8'd3, 8'd3);
    for (int i = 0; i < 9; i++) send_cell(1'b1);
    for (int i = 8; i >= 0; i--) send_cell(ring[i]);
    wait_idle();
  endtask

  // Register values above MAX_DIM are clipped, in each dimension.
  task automatic test_oversize_registers();
    send_gap_pct = 10;
    set_size(8'd200, 8'd1);
    for (int i = 0; i < MAX_DIM; i++) send_cell(1'b1);
    wait_idle();
    set_size(8'd0, 8'd255);
    for (int i = 0; i < MAX_DIM; i++) send_cell(i[0]);
    wait_idle();
  endtask

  // A register write part way through a matrix drops it without a result.
  task automatic test_abandoned_matrix();
    set_size(8'd3, 8'd3);
    for (int i = 0; i < 5; i++) send_cell(1'b1);
    wait_idle();
    write_reg(REG_COL_COUNT, 8'd3);
    for (int i = 0; i < 9; i++) send_cell(1'b1);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while cells keep coming, so the input stalls.
  task automatic test_output_stall();
    send_gap_pct = 0;
    sink_gap_pct = 0;
    set_size(8'd1, 8'd1);
    hold_off_cycles = LONG_HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_cell(1'($urandom_range(1)));
    wait_idle();
    set_size(8'd2, 8'd1);
    hold_off_cycles = LONG_HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_cell(1'($urandom_range(1)));
    wait_idle();
  endtask

  // Random sizes and fill densities, mostly small, with some matrices abandoned.
  task automatic test_random_matrices();
    int unsigned sent, pick, reps, cells, density, cut;
    logic [CFG_W-1:0] rows, cols;
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      // Each phase gets its own idling, sometimes none at all.
      pick = $urandom_range(2);
      send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      pick = $urandom_range(2);
      sink_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
      pick = $urandom_range(99);
      if (pick < 70) begin
        rows = CFG_W'($urandom_range(1, 6));
        cols = CFG_W'($urandom_range(1, 6));
      end else if (pick < 90) begin
        rows = CFG_W'($urandom_range(1, 12));
        cols = CFG_W'($urandom_range(1, 12));
      end else if (pick < 95) begin
        rows = $urandom_range(1) ? 8'd0 : CFG_W'($urandom_range(129, 255));
        cols = CFG_W'($urandom_range(0, 4));
      end else begin
        rows = CFG_W'($urandom_range(1, 2));
        cols = $urandom_range(1) ? CFG_W'(MAX_DIM) : 8'd255;
      end
      if ($urandom_range(1)) begin
        {rows, cols} = {cols, rows};
      end
      set_size(rows, cols);
      cells = dim_in_use(rows) * dim_in_use(cols);
      reps = $urandom_range(1, 4);
      // Back-to-back matrices of one size reuse the line buffer without a restart.
      for (int m = 0; m < reps; m++) begin
        pick = $urandom_range(4);
        density = (pick == 0) ? 0 : (pick == 1) ? 100 : (pick == 2) ? 50 :
                  $urandom_range(75, 98);
        if (cells > 1 && $urandom_range(9) == 0) begin
          cut = $urandom_range(1, cells - 1);
          for (int i = 0; i < cut; i++) send_cell($urandom_range(99) < density);
          wait_idle();
          write_reg(REG_ROW_COUNT, rows);
          sent += cut;
        end else begin
          for (int i = 0; i < cells; i++) send_cell($urandom_range(99) < density);
          sent += cells;
        end
      end
      wait_idle();
    end
  endtask

  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_tiny_sizes();
    test_square_patterns();
    test_oversize_registers();
    test_abandoned_matrix();
    test_output_stall();
    test_random_matrices();
    wait_idle();
    $display("covered: %0d cells, %0d results checked, sizes from 1 to 128 and clipped values",
             cells_sent, results_checked);
    $display("covered: abandoned matrices and %0d long output hold-offs", hold_offs_done);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout at %0t ns with %0d results still owed", $time, best_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
